// ----- hw/rtl/bffla_pkg.sv -----
// Shared types and codes for the best-fit free-list allocator.
// Used by the controller, the datapath and the top level.
`default_nettype none

package bffla_pkg;

  localparam int FIELD_W = 32;

  localparam logic [1:0] FN_ALLOC  = 2'd0;
  localparam logic [1:0] FN_FREE   = 2'd1;
  localparam logic [1:0] FN_REINIT = 2'd2;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_INVALID    = 2'd1;
  localparam logic [1:0] ST_NO_MEM     = 2'd2;
  localparam logic [1:0] ST_TABLE_FULL = 2'd3;

  typedef struct packed {
    logic [1:0]         func;
    logic [FIELD_W-1:0] block_size;
    logic [FIELD_W-1:0] alignment;
    logic [FIELD_W-1:0] block_offset;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [FIELD_W-1:0] granted_offset;
    logic [FIELD_W-1:0] granted_size;
    logic [FIELD_W-1:0] used_bytes;
  } rsp_t;

  typedef enum logic [2:0] {
    WSEL_COPY,
    WSEL_REINIT,
    WSEL_ALLOC_FRONT,
    WSEL_ALLOC_BACK,
    WSEL_MERGE_PREV,
    WSEL_FREE_NEW
  } wr_sel_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC,
    CNT_SET
  } count_op_t;

  typedef enum logic [1:0] {
    USED_HOLD,
    USED_ADD,
    USED_SUB,
    USED_CLEAR
  } used_op_t;

  typedef struct packed {
    logic      latch_req;
    logic      scan_clear;
    logic      scan_rd;
    logic      rd_en;
    logic      wr_en;
    wr_sel_t   wr_sel;
    logic      eval_en;
    logic      commit;
    count_op_t count_op;
    used_op_t  used_op;
    logic [1:0] status;
    logic      grant;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       alloc_bad;
    logic       size_zero;
    logic       found;
    logic       front;
    logic       back;
    logic       mprev;
    logic       mnext;
    logic       full;
    logic       pipe_busy;
    logic       out_free;
  } stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/best_fit_free_list_allocator.sv -----
// Best-fit free-list allocator top level: controller plus datapath.
// Requests are taken one at a time: req_stall is high whenever the controller is not idle.
// Reset (synchronous): clears range count, used count and capacity; table contents
//   stay undefined and need no clearing pass. Uses bffla_pkg, bffla_ctrl, bffla_dp.
`default_nettype none

module best_fit_free_list_allocator #(
  parameter int MAX_RANGES = 64,
  parameter int ADDR_BITS  = 32
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  output logic                 req_stall,
  input  wire bffla_pkg::req_t req,
  output logic                 rsp_valid,
  input  wire logic            rsp_stall,
  output bffla_pkg::rsp_t      rsp,
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic [31:0]     cfg_data
);
  import bffla_pkg::*;

  localparam int AIW = $clog2(MAX_RANGES);
  localparam int CW  = $clog2(MAX_RANGES + 1);

  cmd_t           cmd;
  stat_t          stat;
  logic [CW-1:0]  count, pos;
  logic [AIW-1:0] best_idx, rd_addr, wr_addr;

  assign cfg_ready = 1'b1;

  bffla_ctrl #(.MAX_RANGES(MAX_RANGES)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .count     (count),
    .best_idx  (best_idx),
    .pos       (pos),
    .cmd       (cmd),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr)
  );

  bffla_dp #(.MAX_RANGES(MAX_RANGES), .ADDR_BITS(ADDR_BITS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr),
    .stat      (stat),
    .count     (count),
    .best_idx  (best_idx),
    .pos       (pos),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/bffla_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bffla_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/bffla_dp.sv -----
// Allocator datapath: request and capacity registers, range table RAM,
// scan pipeline, merge/split arithmetic and result register. Uses bffla_pkg, bffla_ram.
`default_nettype none

module bffla_dp #(
  parameter int MAX_RANGES = 64,
  parameter int ADDR_BITS  = 32,
  parameter int AIW        = $clog2(MAX_RANGES),
  parameter int CW         = $clog2(MAX_RANGES + 1)
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire bffla_pkg::req_t      req,
  input  wire logic                 cfg_valid,
  input  wire logic [31:0]          cfg_data,
  input  wire bffla_pkg::cmd_t      cmd,
  input  wire logic [AIW-1:0]       rd_addr,
  input  wire logic [AIW-1:0]       wr_addr,
  output bffla_pkg::stat_t          stat,
  output logic      [CW-1:0]        count,
  output logic      [AIW-1:0]       best_idx,
  output logic      [CW-1:0]        pos,
  output logic                      rsp_valid,
  input  wire logic                 rsp_stall,
  output bffla_pkg::rsp_t           rsp
);
  import bffla_pkg::*;

  localparam int AW = ADDR_BITS;

  logic [AW-1:0] cap;
  logic [1:0]    func;
  logic [AW-1:0] size, align, off;
  logic [AW-1:0] amask;
  logic [AW-1:0] used;

  logic [2*AW-1:0] ram_q, wdata;

  logic           v1, v2;
  logic [AIW-1:0] idx1, st_idx;
  logic [AW-1:0]  st_s, st_l, st_gap;

  logic          found;
  logic [AW-1:0] best_s, best_l, best_gap, best_a;
  logic [AW:0]   best_need;
  logic          has_prev, has_next;
  logic [AW-1:0] prev_s, prev_l, next_s, next_l;

  logic          back, front, mprev, mnext;
  logic [AW-1:0] merge_len, tail_s, tail_l;

  logic [AW:0]   sum_sg, need;
  logic          fit;
  logic [AW-1:0] q_s, q_l;
  logic [AW-1:0] used_next;
  logic [CW-1:0] count_next;

  assign q_s = ram_q[2*AW-1:AW];
  assign q_l = ram_q[AW-1:0];

  bffla_ram #(.WIDTH(2 * AW), .DEPTH(MAX_RANGES)) u_ram (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (wr_addr),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  always_comb begin
    case (cmd.wr_sel)
      WSEL_COPY:        wdata = ram_q;
      WSEL_REINIT:      wdata = {AW'(0), cap};
      WSEL_ALLOC_FRONT: wdata = {best_s, best_gap};
      WSEL_ALLOC_BACK:  wdata = {tail_s, tail_l};
      WSEL_MERGE_PREV:  wdata = {prev_s, prev_l + merge_len};
      WSEL_FREE_NEW:    wdata = {off, merge_len};
      default:          wdata = ram_q;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= '0;
    end else if (cfg_valid) begin
      cap <= AW'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_req) begin
      func  <= req.func;
      size  <= AW'(req.block_size);
      align <= AW'(req.alignment);
      off   <= AW'(req.block_offset);
    end
  end

  assign sum_sg = {1'b0, st_s} + {1'b0, st_gap};
  assign need   = {1'b0, st_gap} + {1'b0, size};
  assign fit    = !sum_sg[AW] && (need <= {1'b0, st_l});

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.scan_rd;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    idx1 <= rd_addr;
    if (v1) begin
      st_s   <= q_s;
      st_l   <= q_l;
      st_gap <= (~q_s + AW'(1)) & amask;
      st_idx <= idx1;
    end
    if (cmd.scan_clear) begin
      amask    <= (align < AW'(4)) ? AW'(3) : align - AW'(1);
      found    <= 1'b0;
      has_prev <= 1'b0;
      has_next <= 1'b0;
      pos      <= count;
    end else if (v2) begin
      if (func == FN_ALLOC) begin
        if (fit && (!found || st_l < best_l)) begin
          found     <= 1'b1;
          best_idx  <= st_idx;
          best_s    <= st_s;
          best_l    <= st_l;
          best_gap  <= st_gap;
          best_need <= need;
          best_a    <= sum_sg[AW-1:0];
        end
      end else if (!found) begin
        if (st_s >= off) begin
          found    <= 1'b1;
          pos      <= CW'(st_idx);
          next_s   <= st_s;
          next_l   <= st_l;
          has_next <= 1'b1;
        end else begin
          prev_s   <= st_s;
          prev_l   <= st_l;
          has_prev <= 1'b1;
        end
      end
    end
    if (cmd.eval_en) begin
      back      <= best_need < {1'b0, best_l};
      front     <= best_gap != '0;
      mprev     <= has_prev && ((prev_s + prev_l) == off);
      mnext     <= has_next && ((off + size) == next_s);
      merge_len <= (has_next && ((off + size) == next_s)) ? size + next_l : size;
      tail_s    <= best_a + size;
      tail_l    <= best_l - best_need[AW-1:0];
    end
  end

  always_comb begin
    case (cmd.count_op)
      CNT_INC: count_next = count + CW'(1);
      CNT_DEC: count_next = count - CW'(1);
      CNT_SET: count_next = (cap != '0) ? CW'(1) : '0;
      default: count_next = count;
    endcase
    case (cmd.used_op)
      USED_ADD:   used_next = used + size;
      USED_SUB:   used_next = used - size;
      USED_CLEAR: used_next = '0;
      default:    used_next = used;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      used      <= '0;
      rsp_valid <= 1'b0;
    end else if (cmd.commit) begin
      count     <= count_next;
      used      <= used_next;
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp.status         <= cmd.status;
      rsp.granted_offset <= cmd.grant ? FIELD_W'(best_a) : '0;
      rsp.granted_size   <= cmd.grant ? FIELD_W'(size) : '0;
      rsp.used_bytes     <= FIELD_W'(used_next);
    end
  end

  always_comb begin
    stat.func      = func;
    stat.alloc_bad = (size == '0) || (align == '0) || ((align & (align - AW'(1))) != '0);
    stat.size_zero = size == '0;
    stat.found     = found;
    stat.front     = front;
    stat.back      = back;
    stat.mprev     = mprev;
    stat.mnext     = mnext;
    stat.full      = count >= CW'(MAX_RANGES);
    stat.pipe_busy = v1 || v2;
    stat.out_free  = !rsp_valid || !rsp_stall;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/bffla_ctrl.sv -----
// Allocator controller: request sequencing, table scan and shift addressing.
// Uses bffla_pkg; drives the datapath through cmd_t, reads stat_t.
`default_nettype none

module bffla_ctrl #(
  parameter int MAX_RANGES = 64,
  parameter int AIW        = $clog2(MAX_RANGES),
  parameter int CW         = $clog2(MAX_RANGES + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             req_valid,
  output logic                  req_stall,
  input  wire bffla_pkg::stat_t stat,
  input  wire logic [CW-1:0]    count,
  input  wire logic [AIW-1:0]   best_idx,
  input  wire logic [CW-1:0]    pos,
  output bffla_pkg::cmd_t       cmd,
  output logic      [AIW-1:0]   rd_addr,
  output logic      [AIW-1:0]   wr_addr
);
  import bffla_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_DECODE = 12'b000000000010,
    S_SCAN   = 12'b000000000100,
    S_EVAL   = 12'b000000001000,
    S_APPLY  = 12'b000000010000,
    S_SHL_RD = 12'b000000100000,
    S_SHL_WR = 12'b000001000000,
    S_SHR_RD = 12'b000010000000,
    S_SHR_WR = 12'b000100000000,
    S_WR_A   = 12'b001000000000,
    S_WR_B   = 12'b010000000000,
    S_FINISH = 12'b100000000000
  } state_t;

  state_t    state, state_next;
  logic [CW-1:0] j, j_next;
  logic [1:0]    status, status_next;
  count_op_t     count_op, count_op_next;
  used_op_t      used_op, used_op_next;
  logic          grant, grant_next;

  logic          is_alloc;
  logic [CW-1:0] j_inc, best_p1, pos_m1, shr_k;
  logic [CW:0]   j_p2;

  assign is_alloc = stat.func == FN_ALLOC;
  assign j_inc    = j + CW'(1);
  assign j_p2     = {1'b0, j} + (CW + 1)'(2);
  assign best_p1  = CW'(best_idx) + CW'(1);
  assign pos_m1   = pos - CW'(1);
  assign shr_k    = is_alloc ? best_p1 : pos;
  assign req_stall = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
    j        <= j_next;
    status   <= status_next;
    count_op <= count_op_next;
    used_op  <= used_op_next;
    grant    <= grant_next;
  end

  always_comb begin
    state_next    = state;
    j_next        = j;
    status_next   = status;
    count_op_next = count_op;
    used_op_next  = used_op;
    grant_next    = grant;
    cmd           = '0;
    cmd.wr_sel    = WSEL_COPY;
    cmd.count_op  = CNT_HOLD;
    cmd.used_op   = USED_HOLD;
    rd_addr       = j[AIW-1:0];
    wr_addr       = j[AIW-1:0];

    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.latch_req = 1'b1;
          state_next    = S_DECODE;
        end
      end

      S_DECODE: begin
        j_next        = '0;
        status_next   = ST_INVALID;
        count_op_next = CNT_HOLD;
        used_op_next  = USED_HOLD;
        grant_next    = 1'b0;
        state_next    = S_FINISH;
        case (stat.func)
          FN_REINIT: begin
            cmd.wr_en     = 1'b1;
            cmd.wr_sel    = WSEL_REINIT;
            wr_addr       = '0;
            status_next   = ST_OK;
            count_op_next = CNT_SET;
            used_op_next  = USED_CLEAR;
          end
          FN_ALLOC: begin
            if (!stat.alloc_bad) begin
              cmd.scan_clear = 1'b1;
              state_next     = S_SCAN;
            end
          end
          FN_FREE: begin
            if (stat.size_zero) begin
              status_next = ST_OK;
            end else begin
              cmd.scan_clear = 1'b1;
              state_next     = S_SCAN;
            end
          end
          default: begin
            status_next = ST_INVALID;
          end
        endcase
      end

      S_SCAN: begin
        if (j < count) begin
          cmd.rd_en   = 1'b1;
          cmd.scan_rd = 1'b1;
          j_next      = j_inc;
        end else if (!stat.pipe_busy) begin
          state_next = S_EVAL;
        end
      end

      S_EVAL: begin
        cmd.eval_en = 1'b1;
        state_next  = S_APPLY;
      end

      S_APPLY: begin
        state_next    = S_FINISH;
        status_next   = ST_OK;
        count_op_next = CNT_HOLD;
        used_op_next  = is_alloc ? USED_ADD : USED_SUB;
        grant_next    = is_alloc;
        if (is_alloc) begin
          if (!stat.found) begin
            status_next  = ST_NO_MEM;
            used_op_next = USED_HOLD;
            grant_next   = 1'b0;
          end else begin
            case ({stat.front, stat.back})
              2'b00: begin
                count_op_next = CNT_DEC;
                j_next        = CW'(best_idx);
                if (best_p1 < count) begin
                  state_next = S_SHL_RD;
                end
              end
              2'b01: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WSEL_ALLOC_BACK;
                wr_addr    = best_idx;
              end
              2'b10: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WSEL_ALLOC_FRONT;
                wr_addr    = best_idx;
              end
              default: begin
                if (stat.full) begin
                  status_next  = ST_TABLE_FULL;
                  used_op_next = USED_HOLD;
                  grant_next   = 1'b0;
                end else begin
                  count_op_next = CNT_INC;
                  if (count > best_p1) begin
                    j_next     = count - CW'(1);
                    state_next = S_SHR_RD;
                  end else begin
                    state_next = S_WR_A;
                  end
                end
              end
            endcase
          end
        end else begin
          case ({stat.mprev, stat.mnext})
            2'b11: begin
              cmd.wr_en     = 1'b1;
              cmd.wr_sel    = WSEL_MERGE_PREV;
              wr_addr       = pos_m1[AIW-1:0];
              count_op_next = CNT_DEC;
              j_next        = pos;
              if (pos + CW'(1) < count) begin
                state_next = S_SHL_RD;
              end
            end
            2'b10: begin
              cmd.wr_en  = 1'b1;
              cmd.wr_sel = WSEL_MERGE_PREV;
              wr_addr    = pos_m1[AIW-1:0];
            end
            2'b01: begin
              cmd.wr_en  = 1'b1;
              cmd.wr_sel = WSEL_FREE_NEW;
              wr_addr    = pos[AIW-1:0];
            end
            default: begin
              if (stat.full) begin
                status_next  = ST_TABLE_FULL;
                used_op_next = USED_HOLD;
              end else begin
                count_op_next = CNT_INC;
                if (count > pos) begin
                  j_next     = count - CW'(1);
                  state_next = S_SHR_RD;
                end else begin
                  state_next = S_WR_A;
                end
              end
            end
          endcase
        end
      end

      S_SHL_RD: begin
        cmd.rd_en  = 1'b1;
        rd_addr    = j_inc[AIW-1:0];
        state_next = S_SHL_WR;
      end

      S_SHL_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WSEL_COPY;
        wr_addr    = j[AIW-1:0];
        j_next     = j_inc;
        state_next = (j_p2 < {1'b0, count}) ? S_SHL_RD : S_FINISH;
      end

      S_SHR_RD: begin
        cmd.rd_en  = 1'b1;
        rd_addr    = j[AIW-1:0];
        state_next = S_SHR_WR;
      end

      S_SHR_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WSEL_COPY;
        wr_addr    = j_inc[AIW-1:0];
        if (j == shr_k) begin
          state_next = S_WR_A;
        end else begin
          j_next     = j - CW'(1);
          state_next = S_SHR_RD;
        end
      end

      S_WR_A: begin
        cmd.wr_en = 1'b1;
        if (is_alloc) begin
          cmd.wr_sel = WSEL_ALLOC_BACK;
          wr_addr    = best_p1[AIW-1:0];
          state_next = S_WR_B;
        end else begin
          cmd.wr_sel = WSEL_FREE_NEW;
          wr_addr    = pos[AIW-1:0];
          state_next = S_FINISH;
        end
      end

      S_WR_B: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WSEL_ALLOC_FRONT;
        wr_addr    = best_idx;
        state_next = S_FINISH;
      end

      S_FINISH: begin
        if (stat.out_free) begin
          cmd.commit   = 1'b1;
          cmd.count_op = count_op;
          cmd.used_op  = used_op;
          cmd.status   = status;
          cmd.grant    = grant;
          state_next   = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire
